// ===== rtl/u8u16_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 stream decoder.
package u8u16_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_END = 2'd1;
  localparam logic [1:0] STATUS_ERR = 2'd2;

  localparam logic [7:0] LEAD_TWO_MIN   = 8'hC2;
  localparam logic [7:0] LEAD_THREE     = 8'hE0;
  localparam logic [7:0] LEAD_FOUR      = 8'hF0;
  localparam logic [7:0] LEAD_LAST      = 8'hF4;
  localparam logic [7:0] LEAD_ANY_MIN   = 8'hC0;
  localparam logic [7:0] E0_SECOND_MIN  = 8'hA0;
  localparam logic [7:0] F0_SECOND_MIN  = 8'h90;
  localparam logic [7:0] F4_SECOND_LIM  = 8'h90;
  localparam logic [5:0] HI_SURR_PREFIX = 6'b110110;
  localparam logic [5:0] LO_SURR_PREFIX = 6'b110111;
  localparam logic [10:0] PLANE_OFFSET  = 11'd64;

  // One classified input byte as it travels through the queue.
  typedef struct packed {
    logic [7:0] data;
    logic       is_cont;
    logic       is_nul;
    logic       is_ascii;
    logic       is_lead;
  } byte_class_t;

  typedef enum logic [2:0] {
    SEQ_IDLE   = 3'd0,
    SEQ_LEAD   = 3'd1,
    SEQ_SECOND = 3'd2,
    SEQ_THIRD  = 3'd3
  } seq_state_t;

endpackage

// ===== rtl/u8u16_byte_if.sv =====
// Byte channel: valid/ready handshake carrying one UTF-8 byte.
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

// ===== rtl/u8u16_unit_if.sv =====
// Unit channel: valid/ready handshake carrying one UTF-16 code unit and status.
interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic [1:0]  status;

  modport source (output valid, output code_unit, output status, input ready);
  modport sink   (input valid, input code_unit, input status, output ready);
endinterface

// ===== rtl/utf8_to_utf16_stream_decoder_core.sv =====
// UTF-8 to UTF-16 stream decoder, top level.
//
// Takes one UTF-8 byte per transfer on byte_ch and returns UTF-16 code units
// on unit_ch, one byte per cycle sustained with no stalls from the sink. An
// ASCII byte yields its unit; two and three byte sequences yield one unit on
// their final byte; a four byte sequence yields the high surrogate on its
// third byte and the low surrogate on its fourth. NUL in idle yields unit 0
// with end status (1). Any malformed byte (stray continuation, lead above
// F4, overlong form, value above U+10FFFF, missing continuation) yields unit
// 0 with error status (2); that byte is consumed and decoding restarts in
// idle. Bytes that only extend a sequence produce no transfer. From byte
// transfer to unit transfer the byte waits in the front queue and its unit
// then in the output register. The front classifies each byte and holds up
// to QueueDepth bytes so input keeps flowing while a finished unit waits on
// the sink; the back state machine decodes one queued byte per cycle
// whenever the output register is free or being drained.
module utf8_to_utf16_stream_decoder_core #(
  parameter int QueueDepth = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  u8u16_byte_if.sink    byte_ch,
  u8u16_unit_if.source  unit_ch
);

  u8u16_pkg::byte_class_t q_item;
  logic                   q_valid;
  logic                   q_pop;

  // classify + buffer
  u8u16_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_ch (byte_ch),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  // decode + output register
  u8u16_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .unit_ch (unit_ch)
  );

endmodule

// ===== rtl/u8u16_front.sv =====
// Front end: classifies incoming bytes and buffers them in a small queue.
module u8u16_front #(
  parameter int QueueDepth = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  u8u16_byte_if.sink                byte_ch,
  output u8u16_pkg::byte_class_t    q_item,
  output logic                      q_valid,
  input  logic                      q_pop
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

  u8u16_pkg::byte_class_t entries [QueueDepth];
  u8u16_pkg::byte_class_t cls;
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  always_comb begin
    cls.data     = byte_ch.byte_in;
    cls.is_cont  = (byte_ch.byte_in[7:6] == 2'b10);
    cls.is_nul   = (byte_ch.byte_in == 8'h00);
    cls.is_ascii = ~byte_ch.byte_in[7];
    cls.is_lead  = (byte_ch.byte_in >= u8u16_pkg::LEAD_ANY_MIN) &&
                   (byte_ch.byte_in <= u8u16_pkg::LEAD_LAST);
  end

  assign byte_ch.ready = (count != CntFull);
  assign push          = byte_ch.valid && byte_ch.ready;
  assign q_valid       = (count != '0);
  assign pop           = q_pop && q_valid;
  assign q_item        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/u8u16_back.sv =====
// Back end: sequence state machine and registered code unit output.
module u8u16_back (
  input  logic                   clk,
  input  logic                   rst,
  input  u8u16_pkg::byte_class_t q_item,
  input  logic                   q_valid,
  output logic                   q_pop,
  u8u16_unit_if.source           unit_ch
);

  u8u16_pkg::seq_state_t seq, seq_next;
  logic [7:0]  lead;
  logic [7:0]  second;
  logic [7:0]  third;
  logic [7:0]  b;
  logic        cont;
  logic        advance;
  logic        bad_second;
  logic        two_ok;
  logic [10:0] hi_bits;
  logic        res_emit;
  logic [15:0] res_unit;
  logic [1:0]  res_status;
  logic        out_free;

  assign b        = q_item.data;
  assign cont     = q_item.is_cont;
  assign out_free = !unit_ch.valid || unit_ch.ready;
  assign advance  = q_valid && out_free;
  assign q_pop    = advance;

  // Second byte checks for three and four byte leads (missing continuation, overlong, above max plane).
  assign bad_second = !cont ||
                      ((lead == u8u16_pkg::LEAD_THREE) && (b < u8u16_pkg::E0_SECOND_MIN)) ||
                      ((lead == u8u16_pkg::LEAD_FOUR) && (b < u8u16_pkg::F0_SECOND_MIN)) ||
                      ((lead == u8u16_pkg::LEAD_LAST) && (b >= u8u16_pkg::F4_SECOND_LIM));
  assign two_ok     = cont && (lead >= u8u16_pkg::LEAD_TWO_MIN);
  // Code point bits 20:10 less the plane offset; low ten bits form the high surrogate.
  assign hi_bits    = {lead[2:0], second[5:0], b[5:4]} - u8u16_pkg::PLANE_OFFSET;

  always_comb begin
    seq_next = seq;
    unique case (seq)
      u8u16_pkg::SEQ_IDLE: begin
        seq_next = q_item.is_lead ? u8u16_pkg::SEQ_LEAD : u8u16_pkg::SEQ_IDLE;
      end
      u8u16_pkg::SEQ_LEAD: begin
        if (lead < u8u16_pkg::LEAD_THREE || bad_second) begin
          seq_next = u8u16_pkg::SEQ_IDLE;
        end else begin
          seq_next = u8u16_pkg::SEQ_SECOND;
        end
      end
      u8u16_pkg::SEQ_SECOND: begin
        if (!cont || lead < u8u16_pkg::LEAD_FOUR) begin
          seq_next = u8u16_pkg::SEQ_IDLE;
        end else begin
          seq_next = u8u16_pkg::SEQ_THIRD;
        end
      end
      default: begin
        seq_next = u8u16_pkg::SEQ_IDLE;
      end
    endcase
  end

  always_comb begin
    res_emit   = 1'b0;
    res_unit   = '0;
    res_status = u8u16_pkg::STATUS_OK;
    unique case (seq)
      u8u16_pkg::SEQ_LEAD: begin
        if (lead < u8u16_pkg::LEAD_THREE) begin
          res_emit = 1'b1;
          if (two_ok) begin
            res_unit = {5'd0, lead[4:0], b[5:0]};
          end else begin
            res_status = u8u16_pkg::STATUS_ERR;
          end
        end else if (bad_second) begin
          res_emit   = 1'b1;
          res_status = u8u16_pkg::STATUS_ERR;
        end
      end
      u8u16_pkg::SEQ_SECOND: begin
        res_emit = 1'b1;
        if (!cont) begin
          res_status = u8u16_pkg::STATUS_ERR;
        end else if (lead < u8u16_pkg::LEAD_FOUR) begin
          res_unit = {lead[3:0], second[5:0], b[5:0]};
        end else begin
          res_unit = {u8u16_pkg::HI_SURR_PREFIX, hi_bits[9:0]};
        end
      end
      u8u16_pkg::SEQ_THIRD: begin
        res_emit = 1'b1;
        if (cont) begin
          res_unit = {u8u16_pkg::LO_SURR_PREFIX, third[3:0], b[5:0]};
        end else begin
          res_status = u8u16_pkg::STATUS_ERR;
        end
      end
      default: begin
        if (q_item.is_nul) begin
          res_emit   = 1'b1;
          res_status = u8u16_pkg::STATUS_END;
        end else if (q_item.is_ascii) begin
          res_emit = 1'b1;
          res_unit = {8'd0, b};
        end else if (!q_item.is_lead) begin
          res_emit   = 1'b1;
          res_status = u8u16_pkg::STATUS_ERR;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq           <= u8u16_pkg::SEQ_IDLE;
      unit_ch.valid <= 1'b0;
    end else begin
      if (advance) begin
        seq <= seq_next;
      end
      if (out_free) begin
        unit_ch.valid <= advance && res_emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      unique case (seq)
        u8u16_pkg::SEQ_IDLE:   lead   <= b;
        u8u16_pkg::SEQ_LEAD:   second <= b;
        u8u16_pkg::SEQ_SECOND: third  <= b;
        default: ;
      endcase
      if (res_emit) begin
        unit_ch.code_unit <= res_unit;
        unit_ch.status    <= res_status;
      end
    end
  end

endmodule

// ===== rtl/u8u16_checker.sv =====
// Port-level checks for the decoder, bound to the top level.
module u8u16_checker (
  input logic        clk,
  input logic        rst,
  input logic        byte_ready,
  input logic        unit_valid,
  input logic        unit_ready,
  input logic [15:0] code_unit,
  input logic [1:0]  status
);

  // held unit must not change while stalled
  a_unit_hold: assert property (@(posedge clk) disable iff (rst)
    unit_valid && !unit_ready |=> unit_valid && $stable(code_unit) && $stable(status))
    else $error("unit changed while stalled");

  // end and error transfers carry a zero unit
  a_zero_unit: assert property (@(posedge clk) disable iff (rst)
    unit_valid && (status != u8u16_pkg::STATUS_OK) |-> (code_unit == 16'd0))
    else $error("nonzero unit with non-ok status");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !unit_valid)
    else $error("unit valid right after reset");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> byte_ready)
    else $error("byte channel not ready after reset");

endmodule

bind utf8_to_utf16_stream_decoder_core u8u16_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .byte_ready (byte_ch.ready),
  .unit_valid (unit_ch.valid),
  .unit_ready (unit_ch.ready),
  .code_unit  (unit_ch.code_unit),
  .status     (unit_ch.status)
);
